[src/lin_slave_frame_handler_assert.svh]
// Assertion macros for the LIN slave frame handler.
// Clocked on i_clk and disabled while i_rst_n is low; no other dependencies.
`ifndef LIN_SLAVE_FRAME_HANDLER_ASSERT_SVH
`define LIN_SLAVE_FRAME_HANDLER_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define LSFH_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// A trigger that must be followed by a condition in the next cycle.
`define LSFH_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (cond)) else $error(msg);

`endif

[src/lsfh_pkg.sv]
// Shared types, codes and helper functions of the LIN slave frame handler.
// No dependencies.
package lsfh_pkg;

    localparam int TABLE_ENTRIES_DEF = 8;
    localparam int ID_W              = 6;
    localparam int ENTRY_W           = 3;
    localparam int LEN_W             = 4;
    localparam int CNT_W             = 4;
    localparam int IDS_W             = 48;
    localparam int DIRS_W            = 8;
    localparam int CFG_W             = 48;
    localparam int MAX_BYTES         = 8;

    localparam logic [7:0] SYNC_BYTE = 8'h55;
    localparam logic [7:0] ID_MASK   = 8'hFC;
    localparam logic [7:0] PAR_MASK  = 8'h03;

    // Command codes on the input tuser.
    localparam logic [1:0] CMD_BREAK = 2'd0;
    localparam logic [1:0] CMD_BUS   = 2'd1;
    localparam logic [1:0] CMD_USER  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_IDS  = 1'b0;
    localparam logic CFG_DIRS = 1'b1;

    // Result kinds on the output tuser.
    localparam logic [2:0] KIND_REQ     = 3'd0;
    localparam logic [2:0] KIND_TX      = 3'd1;
    localparam logic [2:0] KIND_RX      = 3'd2;
    localparam logic [2:0] KIND_BAD_SYN = 3'd3;
    localparam logic [2:0] KIND_BAD_PAR = 3'd4;
    localparam logic [2:0] KIND_UNK_ID  = 3'd5;
    localparam logic [2:0] KIND_BAD_CHK = 3'd6;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SYNC,
        PH_ID,
        PH_TX,
        PH_RX
    } t_phase;

    // A run of results caused by one request; bytes[0] goes out first.
    typedef struct packed {
        logic [2:0]                 kind;
        logic [ENTRY_W-1:0]         entry;
        logic [ID_W-1:0]            frame_id;
        logic [LEN_W-1:0]           data_length;
        logic [CNT_W-1:0]           cnt;
        logic [MAX_BYTES-1:0][7:0]  bytes;
    } t_burst;

    function automatic logic [LEN_W-1:0] len_of(input logic [ID_W-1:0] id);
        logic [LEN_W-1:0] len;
        case (id[1:0])
            2'd3:    len = 4'd8;
            2'd2:    len = 4'd4;
            default: len = 4'd2;
        endcase
        return len;
    endfunction

    // Bit 1 = b7^b6^b5^b3, bit 0 = not(b6^b4^b3^b2).
    function automatic logic [1:0] id_parity(input logic [7:0] b);
        logic p1;
        logic p0;
        p1 = b[7] ^ b[6] ^ b[5] ^ b[3];
        p0 = ~(b[6] ^ b[4] ^ b[3] ^ b[2]);
        return {p1, p0};
    endfunction

endpackage

[src/lin_slave_frame_handler.sv]
// LIN slave frame handler: each request is decoded in the cycle it is accepted,
// and its results leave from a registered output slot one per cycle while
// i_m_tready is high; a result waits in the spare slot while the output is busy.
// Throughput: one request per cycle; a run holds the output until its last result
// is taken; requests stall only while both the output and spare slots are full.
// Reset (synchronous, active low) clears the phase, frame state, table and slots.
module lin_slave_frame_handler #(
    parameter int TABLE_ENTRIES = lsfh_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Configuration write port.
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [lsfh_pkg::CFG_W-1:0] i_cfg_data,
    // Request stream.
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [7:0]                 i_s_tdata,   // [7:0] data
    input  logic [1:0]                 i_s_tuser,   // [1:0] cmd
    // Result stream.
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    // [7:0] byte_out, [10:8] entry, [16:11] frame_id, [20:17] data_length, rest 0
    output logic [23:0]                o_m_tdata,
    output logic [2:0]                 o_m_tuser,   // [2:0] kind
    output logic                       o_m_tlast
);
    import lsfh_pkg::*;

    logic [IDS_W-1:0]            r_table_ids;
    logic [DIRS_W-1:0]           r_table_dirs;

    t_phase                      r_phase, n_phase;
    logic [ENTRY_W-1:0]          r_cur_entry, n_cur_entry;
    logic [ID_W-1:0]             r_cur_id, n_cur_id;
    logic [LEN_W-1:0]            r_left, n_left;
    logic [7:0]                  r_sum, n_sum;
    logic [MAX_BYTES-1:0][7:0]   r_rx_buf;

    logic                        r_out_valid;
    t_burst                      r_out;
    logic                        r_pend_valid;
    t_burst                      r_pend;

    logic                        w_in_acc;
    logic [ID_W-1:0]             w_id;
    logic [LEN_W-1:0]            w_len;
    logic [LEN_W-1:0]            w_cur_len;
    logic                        w_par_ok;
    logic                        w_hit;
    logic [ENTRY_W-1:0]          w_hit_idx;
    logic [7:0]                  w_sum_d;
    logic [LEN_W-1:0]            w_left_dec;
    logic                        w_rx_we;
    logic [2:0]                  w_rx_idx;
    logic                        w_new_valid;
    t_burst                      w_new;
    logic                        w_beat;
    logic                        w_out_free;

    assign o_s_tready = !r_pend_valid;
    assign w_in_acc   = i_s_tvalid && o_s_tready;

    assign w_id      = ID_W'((i_s_tdata & ID_MASK) >> 2);
    assign w_len     = len_of(w_id);
    assign w_par_ok  = (i_s_tdata & PAR_MASK) == {6'd0, id_parity(i_s_tdata)};
    assign w_cur_len = len_of(r_cur_id);
    assign w_sum_d   = r_sum + i_s_tdata;
    assign w_rx_idx  = 3'(w_cur_len - r_left);

    // First matching entry wins, so scan from the top down.
    always_comb begin
        w_hit     = 1'b0;
        w_hit_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (r_table_ids[ID_W*i +: ID_W] == w_id) begin
                w_hit     = 1'b1;
                w_hit_idx = ENTRY_W'(i);
            end
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_cur_entry = r_cur_entry;
        n_cur_id    = r_cur_id;
        n_left      = r_left;
        n_sum       = r_sum;
        w_rx_we     = 1'b0;
        w_new_valid = 1'b0;
        w_new       = '0;
        w_left_dec  = (r_left != '0) ? r_left - 4'd1 : r_left;
        if (w_in_acc) begin
            case (i_s_tuser)
                CMD_BREAK: begin
                    n_phase = PH_SYNC;
                end
                CMD_BUS: begin
                    case (r_phase)
                        PH_SYNC: begin
                            if (i_s_tdata != SYNC_BYTE) begin
                                w_new_valid = 1'b1;
                                w_new.kind  = KIND_BAD_SYN;
                                w_new.cnt   = 4'd1;
                                n_phase     = PH_IDLE;
                            end else begin
                                n_phase = PH_ID;
                            end
                        end
                        PH_ID: begin
                            n_phase           = PH_IDLE;
                            w_new.frame_id    = w_id;
                            w_new.data_length = w_len;
                            w_new.cnt         = 4'd1;
                            if (!w_par_ok) begin
                                w_new_valid = 1'b1;
                                w_new.kind  = KIND_BAD_PAR;
                            end else if (!w_hit) begin
                                w_new_valid = 1'b1;
                                w_new.kind  = KIND_UNK_ID;
                            end else begin
                                n_cur_entry = w_hit_idx;
                                n_cur_id    = w_id;
                                n_left      = w_len;
                                n_sum       = '0;
                                if (r_table_dirs[w_hit_idx]) begin
                                    n_phase = PH_RX;
                                end else begin
                                    n_phase     = PH_TX;
                                    w_new_valid = 1'b1;
                                    w_new.kind  = KIND_REQ;
                                    w_new.entry = w_hit_idx;
                                end
                            end
                        end
                        PH_RX: begin
                            if (r_left != '0) begin
                                w_rx_we = 1'b1;
                                n_sum   = w_sum_d;
                                n_left  = r_left - 4'd1;
                            end else begin
                                n_phase           = PH_IDLE;
                                w_new_valid       = 1'b1;
                                w_new.entry       = r_cur_entry;
                                w_new.frame_id    = r_cur_id;
                                w_new.data_length = w_cur_len;
                                if (~r_sum == i_s_tdata) begin
                                    w_new.kind  = KIND_RX;
                                    w_new.cnt   = w_cur_len;
                                    w_new.bytes = r_rx_buf;
                                end else begin
                                    w_new.kind = KIND_BAD_CHK;
                                    w_new.cnt  = 4'd1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                CMD_USER: begin
                    if (r_phase == PH_TX) begin
                        w_new_valid       = 1'b1;
                        w_new.kind        = KIND_TX;
                        w_new.entry       = r_cur_entry;
                        w_new.frame_id    = r_cur_id;
                        w_new.data_length = w_cur_len;
                        w_new.bytes[0]    = i_s_tdata;
                        n_sum             = w_sum_d;
                        n_left            = w_left_dec;
                        if (w_left_dec == '0) begin
                            // Final data byte: the checksum follows it.
                            w_new.cnt      = 4'd2;
                            w_new.bytes[1] = ~w_sum_d;
                            n_phase        = PH_IDLE;
                        end else begin
                            w_new.cnt = 4'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_cur_entry  <= '0;
            r_cur_id     <= '0;
            r_left       <= '0;
            r_sum        <= '0;
            r_table_ids  <= '0;
            r_table_dirs <= '0;
        end else begin
            r_phase     <= n_phase;
            r_cur_entry <= n_cur_entry;
            r_cur_id    <= n_cur_id;
            r_left      <= n_left;
            r_sum       <= n_sum;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IDS:  r_table_ids  <= i_cfg_data[IDS_W-1:0];
                    CFG_DIRS: r_table_dirs <= i_cfg_data[DIRS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rx_we) begin
            r_rx_buf[w_rx_idx] <= i_s_tdata;
        end
    end

    // Output slot plus one spare slot; the spare fills only while the output is busy.
    assign w_beat     = r_out_valid && i_m_tready;
    assign w_out_free = !r_out_valid || (w_beat && r_out.cnt == 4'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (w_out_free) begin
            if (r_pend_valid) begin
                r_out_valid  <= 1'b1;
                r_pend_valid <= 1'b0;
            end else begin
                r_out_valid <= w_new_valid;
            end
        end else if (w_new_valid) begin
            r_pend_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_pend_valid) begin
                r_out <= r_pend;
            end else begin
                r_out <= w_new;
            end
        end else begin
            if (w_beat) begin
                r_out.cnt   <= r_out.cnt - 4'd1;
                r_out.bytes <= r_out.bytes >> 8;
            end
            if (w_new_valid) begin
                r_pend <= w_new;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tlast  = r_out.cnt == 4'd1;
    assign o_m_tdata  = {3'd0, r_out.data_length, r_out.frame_id, r_out.entry,
                         r_out.bytes[0]};

`include "lin_slave_frame_handler_assert.svh"

    `LSFH_ASSERT_ALWAYS(a_pend_behind_out, !r_pend_valid || r_out_valid,
        "spare slot holds a run while the output slot is empty")
    `LSFH_ASSERT_ALWAYS(a_out_cnt_range,
        !r_out_valid || (r_out.cnt != '0 && r_out.cnt <= 4'd8),
        "output run length out of range")
    `LSFH_ASSERT_ALWAYS(a_rx_left_bound, r_phase != PH_RX || r_left <= w_cur_len,
        "receive byte count exceeds frame length")
    `LSFH_ASSERT_NEXT(a_beat_advance, w_beat && r_out.cnt > 4'd1,
        r_out_valid && r_out.cnt == $past(r_out.cnt) - 4'd1,
        "multi-result run did not advance after a taken beat")

endmodule
